>>> design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define CHK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/cspg_pkg.sv
`default_nettype none
package cspg_pkg;

    // round structure: each double round is eight add-xor-rotate steps
    localparam int DOUBLE_ROUNDS = 10;
    localparam int STEPS_PER_DR  = 8;
    localparam int NUM_CELLS     = DOUBLE_ROUNDS * STEPS_PER_DR;

    // block constant words
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    // key whitening words
    localparam logic [31:0] KEY_XOR0 = 32'hA5A5A5A5;
    localparam logic [31:0] KEY_XOR1 = 32'h3C6EF372;
    localparam logic [31:0] KEY_XOR2 = 32'h9E3779B9;
    localparam logic [31:0] KEY_XOR3 = 32'hC3EFE9DB;

    // fixed nonce
    localparam logic [31:0] NONCE0 = 32'hDEADBEEF;
    localparam logic [31:0] NONCE1 = 32'hFEEDFACE;
    localparam logic [31:0] NONCE2 = 32'h12345678;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SEED_HIGH = 2'd0,
        CFG_SEED_LOW  = 2'd1,
        CFG_WORD_BITS = 2'd2
    } cfg_reg_t;

    // step select of one cell: bit 2 diagonal, bits 1:0 phase
    typedef logic [2:0] step_sel_t;

    // one working state travelling down the chain
    typedef struct packed {
        logic              valid;
        logic [15:0][31:0] w;
    } cspg_beat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

endpackage
`default_nettype wire

>>> design/cspg_cell.sv
`default_nettype none
module cspg_cell
    import cspg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire step_sel_t  step_i,
    input  wire cspg_beat_t beat_i,
    output cspg_beat_t      beat_o
);

    cspg_beat_t beat_reg;
    cspg_beat_t beat_next;

    // one add-xor-rotate step on all four quarter rounds in parallel
    always_comb begin
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] sum;
        logic [4:0]  rot;
        logic        dg;
        dg = step_i[2];
        case (step_i[1:0])
            2'd0:    rot = 5'd16;
            2'd1:    rot = 5'd12;
            2'd2:    rot = 5'd8;
            default: rot = 5'd7;
        endcase
        beat_next = beat_i;
        for (int q = 0; q < 4; q++) begin
            ia = {2'b00, 2'(q)};
            ib = {2'b01, 2'(q + int'(dg))};
            ic = {2'b10, 2'(q + 2 * int'(dg))};
            id = {2'b11, 2'(q + 3 * int'(dg))};
            if (!step_i[0]) begin
                // a += b; d ^= a; d <<<= r
                sum = beat_i.w[ia] + beat_i.w[ib];
                beat_next.w[ia] = sum;
                beat_next.w[id] = rotl32(beat_i.w[id] ^ sum, rot);
            end else begin
                // c += d; b ^= c; b <<<= r
                sum = beat_i.w[ic] + beat_i.w[id];
                beat_next.w[ic] = sum;
                beat_next.w[ib] = rotl32(beat_i.w[ib] ^ sum, rot);
            end
        end
    end

    // stage register, only the valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (en) begin
            beat_reg.valid <= beat_next.valid;
        end
        if (en) begin
            beat_reg.w <= beat_next.w;
        end
    end

    assign beat_o = beat_reg;

endmodule
`default_nettype wire

>>> design/chacha20_share_pair_generator_core.sv
// An accepted input beat passes through the 80 round-step cells, then the
// feed-forward and mask output register, before its result shows on m_tvalid.
// Throughput: one beat per cycle; the whole cell chain advances together and
// holds while a result waits on m_tready.
// Reset: aresetn is synchronous, active low; it clears all valid bits and sets
// the seeds to zero and word_bits to 64.
`default_nettype none
module chacha20_share_pair_generator_core
    import cspg_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] triple_index
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // [63:0] share_a, [127:64] share_b
);

    logic [63:0]  seed_high_reg;
    logic [63:0]  seed_low_reg;
    logic [6:0]   word_bits_reg;
    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic [127:0] m_tdata_next;
    logic         en;
    logic [31:0]  s0, s1, s2, s3;
    logic [63:0]  mask;
    logic [31:0]  w0, w1, w2, w3;
    cspg_beat_t   chain [0:NUM_CELLS];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_high_reg <= '0;
            seed_low_reg  <= '0;
            word_bits_reg <= 7'd64;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SEED_HIGH: seed_high_reg <= cfg_data;
                CFG_SEED_LOW:  seed_low_reg  <= cfg_data;
                CFG_WORD_BITS: word_bits_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // chain advances unless a held result blocks the output register
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // initial state from seeds, counter and nonce
    assign s0 = seed_low_reg[31:0];
    assign s1 = seed_low_reg[63:32];
    assign s2 = seed_high_reg[31:0];
    assign s3 = seed_high_reg[63:32];

    always_comb begin
        chain[0].valid = s_tvalid;
        chain[0].w[0]  = SIGMA0;
        chain[0].w[1]  = SIGMA1;
        chain[0].w[2]  = SIGMA2;
        chain[0].w[3]  = SIGMA3;
        chain[0].w[4]  = s0 ^ KEY_XOR0;
        chain[0].w[5]  = s1 ^ KEY_XOR1;
        chain[0].w[6]  = s2 ^ KEY_XOR2;
        chain[0].w[7]  = s3 ^ KEY_XOR3;
        chain[0].w[8]  = s0 ^ s2;
        chain[0].w[9]  = s1 ^ s3;
        chain[0].w[10] = s0 ^ s3;
        chain[0].w[11] = s1 ^ s2;
        chain[0].w[12] = s_tdata;
        chain[0].w[13] = NONCE0;
        chain[0].w[14] = NONCE1;
        chain[0].w[15] = NONCE2;
    end

    // row of round-step cells
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cspg_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .step_i  (step_sel_t'(g % STEPS_PER_DR)),
            .beat_i  (chain[g]),
            .beat_o  (chain[g + 1])
        );
    end

    // feed-forward on the first four words (their initial values are constants)
    assign w0 = chain[NUM_CELLS].w[0] + SIGMA0;
    assign w1 = chain[NUM_CELLS].w[1] + SIGMA1;
    assign w2 = chain[NUM_CELLS].w[2] + SIGMA2;
    assign w3 = chain[NUM_CELLS].w[3] + SIGMA3;

    // widths of 64 and above keep every bit
    assign mask = word_bits_reg[6] ? {64{1'b1}} : ~({64{1'b1}} << word_bits_reg[5:0]);

    assign m_tdata_next = {({w2, w3} & mask), ({w0, w1} & mask)};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain[NUM_CELLS].valid;
        end
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

>>> design/cspg_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cspg_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata
);

    // a waiting result beat stays offered
    `CHK_ASSERT_NXT(a_m_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // a waiting result beat keeps its data
    `CHK_ASSERT_NXT(a_m_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // input side stalls exactly when a result is blocked
    `CHK_ASSERT_IMP(a_s_ready_follows, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))

    // no result beat right after reset
    `CHK_ASSERT_NXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

bind chacha20_share_pair_generator_core cspg_checker u_cspg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import cspg_pkg::*;

    // register index that maps to nothing, writes there are dropped
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_sel;
        logic [63:0] value;
        logic        typed;
        logic [63:0] exp_a;
        logic [63:0] exp_b;
    } dir_row_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
    } share_pair_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;    // [31:0] triple_index
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // [63:0] share_a, [127:64] share_b

    // mirror of the block's registers
    logic [63:0]  seed_hi_q;
    logic [63:0]  seed_lo_q;
    logic [6:0]   width_q;

    share_pair_t  pending_shares[$];
    int           fail_count;
    int           items_sent;
    int           rx_mode;
    int           rx_tick;
    bit           hold_req;
    int           burst_left;
    logic [31:0]  run_counter;

    // directed rows: extremes of index and seeds, width corners, unmapped write
    dir_row_t dir_rows [28] = '{
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0000, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0001, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_8000_0000, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_SEED_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_SEED_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0000, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_SEED_HIGH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_SEED_LOW,  64'h5555_5555_5555_5555, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_5555_AAAA, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_AAAA_5555, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_WORD_BITS, 64'h0000_0000_0000_0000, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0000, 1'b1, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_FFFF_FFFF, 1'b1, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_WORD_BITS, 64'h0000_0000_0000_0001, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_1234_5678, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_WORD_BITS, 64'h0000_0000_0000_003F, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_9ABC_DEF0, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_WORD_BITS, 64'h0000_0000_0000_007F, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0007, 1'b0, 64'h0, 64'h0},
        // upper data bits are dropped, width lands on zero
        '{ROW_CFG,  CFG_WORD_BITS, 64'hFFFF_FFFF_FFFF_FF80, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0003, 1'b1, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_WORD_BITS, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_UNMAPPED,  64'h0123_4567_89AB_CDEF, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_DEAD_BEEF, 1'b0, 64'h0, 64'h0},
        '{ROW_CFG,  CFG_SEED_HIGH, 64'h0000_0000_0000_0000, 1'b0, 64'h0, 64'h0},
        '{ROW_ITEM, CFG_UNMAPPED,  64'h0000_0000_0000_0040, 1'b0, 64'h0, 64'h0}
    };

    chacha20_share_pair_generator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // rotate left through a doubled word
    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        logic [63:0] twice;
        twice = {v, v} << n;
        return twice[63:32];
    endfunction

    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        a = a + b; d = rol(d ^ a, 16);
        c = c + d; b = rol(b ^ c, 12);
        a = a + b; d = rol(d ^ a, 8);
        c = c + d; b = rol(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // block function keyed from the mirrored seeds, then width mask
    function automatic share_pair_t chacha_shares(input logic [31:0] ctr);
        logic [31:0] s0, s1, s2, s3;
        logic [31:0] st0 [16];
        logic [31:0] x [16];
        logic [63:0] keep;
        share_pair_t res;
        s0 = seed_lo_q[31:0];
        s1 = seed_lo_q[63:32];
        s2 = seed_hi_q[31:0];
        s3 = seed_hi_q[63:32];
        st0[0]  = SIGMA0;         st0[1]  = SIGMA1;
        st0[2]  = SIGMA2;         st0[3]  = SIGMA3;
        st0[4]  = s0 ^ KEY_XOR0;  st0[5]  = s1 ^ KEY_XOR1;
        st0[6]  = s2 ^ KEY_XOR2;  st0[7]  = s3 ^ KEY_XOR3;
        st0[8]  = s0 ^ s2;        st0[9]  = s1 ^ s3;
        st0[10] = s0 ^ s3;        st0[11] = s1 ^ s2;
        st0[12] = ctr;            st0[13] = NONCE0;
        st0[14] = NONCE1;         st0[15] = NONCE2;
        for (int i = 0; i < 16; i++) x[i] = st0[i];
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            // columns
            {x[0], x[4], x[8],  x[12]} = qround(x[0], x[4], x[8],  x[12]);
            {x[1], x[5], x[9],  x[13]} = qround(x[1], x[5], x[9],  x[13]);
            {x[2], x[6], x[10], x[14]} = qround(x[2], x[6], x[10], x[14]);
            {x[3], x[7], x[11], x[15]} = qround(x[3], x[7], x[11], x[15]);
            // diagonals
            {x[0], x[5], x[10], x[15]} = qround(x[0], x[5], x[10], x[15]);
            {x[1], x[6], x[11], x[12]} = qround(x[1], x[6], x[11], x[12]);
            {x[2], x[7], x[8],  x[13]} = qround(x[2], x[7], x[8],  x[13]);
            {x[3], x[4], x[9],  x[14]} = qround(x[3], x[4], x[9],  x[14]);
        end
        for (int i = 0; i < 4; i++) x[i] = x[i] + st0[i];
        keep = (width_q >= 7'd64) ? '1 : ((64'd1 << width_q) - 64'd1);
        res.a = {x[0], x[1]} & keep;
        res.b = {x[2], x[3]} & keep;
        return res;
    endfunction

    // one input beat; expectation queued on acceptance
    task automatic send_index(input logic [31:0] idx, input bit typed,
                              input logic [63:0] ea, input logic [63:0] eb);
        share_pair_t want;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (typed) begin
            want.a = ea;
            want.b = eb;
        end else begin
            want = chacha_shares(idx);
        end
        pending_shares.push_back(want);
        items_sent++;
    endtask

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
        end
    endtask

    // let the pipe empty out before touching registers
    task automatic wait_drained();
        idle_input(1);
        while (pending_shares.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (sel)
            CFG_SEED_HIGH: seed_hi_q = val;
            CFG_SEED_LOW:  seed_lo_q = val;
            CFG_WORD_BITS: width_q   = val[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_data  <= {$urandom, $urandom};
    endtask

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_width();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       v[6:0] = 7'd0;
            1:       v[6:0] = 7'd64;
            2:       v[6:0] = 7'd127;
            3:       v[6:0] = 7'd1;
            4:       v[6:0] = 7'd63;
            default: v[6:0] = 7'($urandom_range(0, 127));
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    begin
                run_counter = run_counter + 32'd1;
                return run_counter;
            end
            default: return $urandom;
        endcase
    endfunction

    // stream of random indexes, optionally in bursts with gaps
    task automatic send_stream(input int n, input bit bursty);
        for (int i = 0; i < n; i++) begin
            if (bursty && burst_left == 0) begin
                idle_input($urandom_range(1, 8));
                burst_left = $urandom_range(1, 20);
            end
            send_index(pick_index(), 1'b0, 64'h0, 64'h0);
            if (burst_left > 0) burst_left--;
        end
    endtask

    // receiver stall pattern, with a long hold when asked
    initial begin
        m_tready = 1'b0;
        rx_tick  = 0;
        forever begin
            @(negedge aclk);
            rx_tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((rx_tick % 7) < 4);
                endcase
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        share_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_shares.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_shares.pop_front();
                if (m_tdata[63:0] !== want.a) begin
                    $error("share_a expected %h actual %h", want.a, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[127:64] !== want.b) begin
                    $error("share_b expected %h actual %h", want.b, m_tdata[127:64]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("** chacha20_share_pair_generator_core: FAILED **");
        $finish;
    end

    initial begin
        int phase;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SEED_HIGH;
        cfg_data    = 64'h0;
        s_tvalid    = 1'b0;
        s_tdata     = 32'h0;
        seed_hi_q   = 64'h0;
        seed_lo_q   = 64'h0;
        width_q     = 7'd64;
        fail_count  = 0;
        items_sent  = 0;
        rx_mode     = 1;
        hold_req    = 1'b0;
        burst_left  = 0;
        run_counter = $urandom;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
            end else begin
                if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 3));
                send_index(dir_rows[i].value[31:0], dir_rows[i].typed,
                           dir_rows[i].exp_a, dir_rows[i].exp_b);
            end
        end

        // random phases, fresh settings each time
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_drained();
            write_reg(CFG_SEED_HIGH, pick_seed());
            write_reg(CFG_SEED_LOW, pick_seed());
            write_reg(CFG_WORD_BITS, pick_width());
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED, {$urandom, $urandom});
            rx_mode = $urandom_range(0, 3);
            if (phase == 2) begin
                // receiver holds off while the sender keeps pushing
                hold_req = 1'b1;
                send_stream(150, 1'b0);
            end else if (phase == 4) begin
                send_stream(30, 1'b1);
                idle_input(1);
                while (pending_shares.size() != 0) @(posedge aclk);
                send_stream(30, 1'b1);
            end else begin
                send_stream($urandom_range(40, 90), $urandom_range(0, 3) != 0);
            end
            phase++;
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending_shares.size() == 0) begin
            $display("** chacha20_share_pair_generator_core: PASSED **");
        end else begin
            $display("** chacha20_share_pair_generator_core: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
